[src/fnth_pkg.sv]
// fnth_pkg: shared constants, widths and the permutation rom for the terrain height generator
// no dependencies; imported by every module of the block
package fnth_pkg;

    // fixed point format, fraction bits of every real value
    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;

    // default values for the top level parameters
    localparam int OCTAVES_DEF    = 3;
    localparam int MAX_HEIGHT_DEF = 64;

    // field widths
    localparam int COORD_W  = 16;
    localparam int SEED_W   = 16;
    localparam int HEIGHT_W = 7;
    localparam int CELL_W   = 8;
    localparam int POS_W    = CELL_W + FRAC_BITS;

    // apb register map, word index taken from paddr[2]
    localparam int  DATA_W   = 32;
    localparam int  ADDR_W   = 3;
    localparam logic REG_SEED = 1'b0;

    // truncated fixed point constants
    localparam int K_OFF_X = (132 * ONE) / 1000;
    localparam int K_OFF_Z = (941 * ONE) / 1000;
    localparam int K_OFF_Y = (42 * ONE) / 100;
    localparam int K_FREQ  = (5 * ONE) / 100;

    // datapath widths inside one octave
    localparam int T_W   = FRAC_BITS + 1;   // fade input, signed
    localparam int A_W   = FRAC_BITS + 5;   // 6t - 15, signed
    localparam int B_W   = FRAC_BITS + 5;   // t*(6t-15) + 10, signed
    localparam int F_W   = FRAC_BITS + 2;   // fade output, signed
    localparam int X_W   = FRAC_BITS + 2;   // corner offset, signed
    localparam int G_W   = FRAC_BITS + 3;   // gradient and lerp values, signed
    localparam int PR_W  = F_W + G_W + 1;   // lerp product

    // pipeline depth
    localparam int OCT_STAGES = 10;
    localparam int NUM_STAGES = OCT_STAGES + 6;

    // fixed permutation table
    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

endpackage

[src/fnth_octave.sv]
// fnth_octave: one octave of improved 3d gradient noise, ten register stages
// depends on fnth_pkg (widths, permutation rom); stage enables come from the top level
module fnth_octave (
    input  logic                                   clk,
    input  logic [fnth_pkg::OCT_STAGES-1:0]        en,
    input  logic [fnth_pkg::POS_W-1:0]             px,
    input  logic [fnth_pkg::POS_W-1:0]             py,
    input  logic [fnth_pkg::POS_W-1:0]             pz,
    output logic signed [fnth_pkg::G_W-1:0]        noise
);
    import fnth_pkg::*;

    localparam int M1_W = T_W + A_W;
    localparam int M2_W = 2 * T_W;
    localparam int FP_W = T_W + B_W;

    localparam logic signed [A_W-1:0] FIFTEEN = A_W'(15 * ONE);
    localparam logic signed [B_W-1:0] TEN     = B_W'(10 * ONE);

    // gradient select over the 16 hash codes
    function automatic logic signed [G_W-1:0] grad(
        input logic [3:0]              h,
        input logic signed [X_W-1:0]   x,
        input logic signed [X_W-1:0]   y,
        input logic signed [X_W-1:0]   z
    );
        logic signed [G_W-1:0] u;
        logic signed [G_W-1:0] v;
        u = (h < 4'd8) ? G_W'(x) : G_W'(y);
        if (h < 4'd4)
        begin
            v = G_W'(y);
        end
        else if (h == 4'd12 || h == 4'd14)
        begin
            v = G_W'(x);
        end
        else
        begin
            v = G_W'(z);
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // stage 0: fade products, first hash level
    logic [FRAC_BITS-1:0]       frac [3];
    logic signed [M1_W-1:0]     m1_next [3];
    logic signed [M1_W-1:0]     m1_reg [3];
    logic signed [M2_W-1:0]     m2_next [3];
    logic signed [M2_W-1:0]     m2_reg [3];
    logic [FRAC_BITS-1:0]       frac0_reg [3];
    logic [CELL_W-1:0]          hxy_next [2];
    logic [CELL_W-1:0]          hxy_reg [2];
    logic [CELL_W-1:0]          cz0_reg;

    assign frac[0] = px[FRAC_BITS-1:0];
    assign frac[1] = py[FRAC_BITS-1:0];
    assign frac[2] = pz[FRAC_BITS-1:0];

    always_comb
    begin
        logic signed [T_W-1:0] t;
        logic signed [A_W-1:0] a;
        for (int i = 0; i < 3; i++)
        begin
            t = $signed({1'b0, frac[i]});
            a = A_W'(t * 6) - FIFTEEN;
            m1_next[i] = t * a;
            m2_next[i] = t * t;
        end
        for (int i = 0; i < 2; i++)
        begin
            hxy_next[i] = PERM_ROM[CELL_W'(px[POS_W-1:FRAC_BITS] + CELL_W'(i))]
                          + py[POS_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            frac0_reg <= frac;
            hxy_reg   <= hxy_next;
            cz0_reg   <= pz[POS_W-1:FRAC_BITS];
        end
    end

    // stage 1: fade second level, second hash level
    logic signed [B_W-1:0]      fb_next [3];
    logic signed [B_W-1:0]      fb_reg [3];
    logic signed [M2_W-1:0]     t3p_next [3];
    logic signed [M2_W-1:0]     t3p_reg [3];
    logic [FRAC_BITS-1:0]       frac1_reg [3];
    logic [CELL_W-1:0]          base_next [4];
    logic [CELL_W-1:0]          base_reg [4];

    always_comb
    begin
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] t2;
        for (int i = 0; i < 3; i++)
        begin
            t = $signed({1'b0, frac0_reg[i]});
            fb_next[i] = B_W'(m1_reg[i] >>> FRAC_BITS) + TEN;
            t2 = T_W'(m2_reg[i] >>> FRAC_BITS);
            t3p_next[i] = t2 * t;
        end
        // corner index: bit 0 picks x+1, bit 1 picks y+1
        for (int k = 0; k < 4; k++)
        begin
            base_next[k] = PERM_ROM[CELL_W'(hxy_reg[1'(k)] + CELL_W'(k >> 1))] + cz0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            fb_reg    <= fb_next;
            t3p_reg   <= t3p_next;
            frac1_reg <= frac0_reg;
            base_reg  <= base_next;
        end
    end

    // stage 2: fade final product, gradient hashes
    logic signed [FP_W-1:0]     fp_next [3];
    logic signed [FP_W-1:0]     fp_reg [3];
    logic [FRAC_BITS-1:0]       frac2_reg [3];
    logic [3:0]                 h_next [8];
    logic [3:0]                 h_reg [8];

    always_comb
    begin
        logic signed [T_W-1:0] t3;
        logic [CELL_W-1:0]     idx;
        for (int i = 0; i < 3; i++)
        begin
            t3 = T_W'(t3p_reg[i] >>> FRAC_BITS);
            fp_next[i] = t3 * fb_reg[i];
        end
        // bit 2 of the corner index picks z+1
        for (int c = 0; c < 8; c++)
        begin
            idx = base_reg[2'(c)] + CELL_W'(c >> 2);
            h_next[c] = PERM_ROM[idx][3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            fp_reg    <= fp_next;
            frac2_reg <= frac1_reg;
            h_reg     <= h_next;
        end
    end

    // stage 3: fade outputs and the eight corner gradients
    logic signed [F_W-1:0]      f_next [3];
    logic signed [F_W-1:0]      f_reg [3];
    logic signed [G_W-1:0]      g_next [8];
    logic signed [G_W-1:0]      g_reg [8];

    always_comb
    begin
        logic signed [X_W-1:0] cx;
        logic signed [X_W-1:0] cy;
        logic signed [X_W-1:0] cz;
        for (int i = 0; i < 3; i++)
        begin
            f_next[i] = F_W'(fp_reg[i] >>> FRAC_BITS);
        end
        for (int c = 0; c < 8; c++)
        begin
            cx = $signed({2'b00, frac2_reg[0]}) - (c[0] ? X_W'(ONE) : X_W'(0));
            cy = $signed({2'b00, frac2_reg[1]}) - (c[1] ? X_W'(ONE) : X_W'(0));
            cz = $signed({2'b00, frac2_reg[2]}) - (c[2] ? X_W'(ONE) : X_W'(0));
            g_next[c] = grad(h_reg[c], cx, cy, cz);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            f_reg <= f_next;
            g_reg <= g_next;
        end
    end

    // stage 4: x lerp products
    logic signed [PR_W-1:0]     px_next [4];
    logic signed [PR_W-1:0]     px_reg [4];
    logic signed [G_W-1:0]      gx_reg [4];
    logic signed [F_W-1:0]      fv4_reg;
    logic signed [F_W-1:0]      fw4_reg;

    always_comb
    begin
        logic signed [G_W:0] d;
        for (int k = 0; k < 4; k++)
        begin
            d = (G_W+1)'(g_reg[2*k+1]) - (G_W+1)'(g_reg[2*k]);
            px_next[k] = f_reg[0] * d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            px_reg  <= px_next;
            for (int k = 0; k < 4; k++)
            begin
                gx_reg[k] <= g_reg[2*k];
            end
            fv4_reg <= f_reg[1];
            fw4_reg <= f_reg[2];
        end
    end

    // stage 5: x lerp sums
    logic signed [G_W-1:0]      l_reg [4];
    logic signed [F_W-1:0]      fv5_reg;
    logic signed [F_W-1:0]      fw5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int k = 0; k < 4; k++)
            begin
                l_reg[k] <= gx_reg[k] + G_W'(px_reg[k] >>> FRAC_BITS);
            end
            fv5_reg <= fv4_reg;
            fw5_reg <= fw4_reg;
        end
    end

    // stage 6: y lerp products
    logic signed [PR_W-1:0]     py_next [2];
    logic signed [PR_W-1:0]     py_reg [2];
    logic signed [G_W-1:0]      ly_reg [2];
    logic signed [F_W-1:0]      fw6_reg;

    always_comb
    begin
        logic signed [G_W:0] d;
        for (int k = 0; k < 2; k++)
        begin
            d = (G_W+1)'(l_reg[2*k+1]) - (G_W+1)'(l_reg[2*k]);
            py_next[k] = fv5_reg * d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            py_reg    <= py_next;
            ly_reg[0] <= l_reg[0];
            ly_reg[1] <= l_reg[2];
            fw6_reg   <= fw5_reg;
        end
    end

    // stage 7: y lerp sums
    logic signed [G_W-1:0]      m_reg [2];
    logic signed [F_W-1:0]      fw7_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            for (int k = 0; k < 2; k++)
            begin
                m_reg[k] <= ly_reg[k] + G_W'(py_reg[k] >>> FRAC_BITS);
            end
            fw7_reg <= fw6_reg;
        end
    end

    // stage 8: z lerp product
    logic signed [PR_W-1:0]     pzl_reg;
    logic signed [G_W-1:0]      mz_reg;
    logic signed [G_W:0]        dz;

    assign dz = (G_W+1)'(m_reg[1]) - (G_W+1)'(m_reg[0]);

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            pzl_reg <= fw7_reg * dz;
            mz_reg  <= m_reg[0];
        end
    end

    // stage 9: z lerp sum, octave noise value
    logic signed [G_W-1:0]      noise_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            noise_reg <= mz_reg + G_W'(pzl_reg >>> FRAC_BITS);
        end
    end

    assign noise = noise_reg;

endmodule

[src/fractal_noise_terrain_height.sv]
// fractal_noise_terrain_height: column coordinates in, fractal noise terrain height out
// depends on fnth_pkg and fnth_octave (one instance per octave)
// path: offset, scale, octave, sum, reciprocal, quotient and output stages to height_valid
// throughput: one column per cycle; a stall holds a stage only when it and every later stage are full
// reset: clears the valid bits of all stages and the seed register (seed 0)
// the apb port has no wait states; the user must write the seed while the pipeline is empty (not enforced)
module fractal_noise_terrain_height #(
    parameter int OCTAVES    = fnth_pkg::OCTAVES_DEF,
    parameter int MAX_HEIGHT = fnth_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // apb configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fnth_pkg::ADDR_W-1:0]          paddr,
    input  logic [fnth_pkg::DATA_W-1:0]          pwdata,
    output logic [fnth_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    // column channel
    input  logic                                 column_valid,
    output logic                                 column_stall,
    input  logic signed [fnth_pkg::COORD_W-1:0]  column_x,
    input  logic signed [fnth_pkg::COORD_W-1:0]  column_z,
    // height channel
    output logic                                 height_valid,
    input  logic                                 height_stall,
    output logic [fnth_pkg::HEIGHT_W-1:0]        height
);
    import fnth_pkg::*;

    // amplitude total reduces to 2^(F+1-O) * (2^O - 1), so the normalize
    // step is |sum| * 2^(O-1) divided by DIV, truncated toward zero
    localparam int          DIV   = (1 << OCTAVES) - 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / DIV);
    localparam int          AX_W  = COORD_W + FRAC_BITS + 2;
    localparam int          SUM_W = G_W + 3;
    localparam int          NN_W  = SUM_W + OCTAVES - 1;
    localparam int          V_W   = NN_W + 12;
    localparam int          OCT0  = 2;
    localparam int          S_SUM = OCT0 + OCT_STAGES;
    localparam int          S_REC = S_SUM + 1;
    localparam int          S_Q   = S_SUM + 2;
    localparam int          S_OUT = S_SUM + 3;

    // configuration register and derived offsets
    logic [SEED_W-1:0]  seed_reg;
    logic [31:0]        offx_reg;
    logic [31:0]        offz_reg;
    logic [POS_W-1:0]   offy_reg;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEED) ? DATA_W'(seed_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            offx_reg <= '0;
            offz_reg <= '0;
            offy_reg <= '0;
        end
        else if (cfg_wr)
        begin
            seed_reg <= pwdata[SEED_W-1:0];
            offx_reg <= 32'(pwdata[SEED_W-1:0] * 32'(K_OFF_X));
            offz_reg <= 32'(pwdata[SEED_W-1:0] * 32'(K_OFF_Z));
            offy_reg <= POS_W'(pwdata[SEED_W-1:0] * 32'(K_OFF_Y));
        end
    end

    // pipeline control: a stage loads unless the height side stalls and it and every stage after it are full
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_in;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        logic [NUM_STAGES-1:0] low_mask;
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            low_mask = (NUM_STAGES'(1) << k) - NUM_STAGES'(1);
            en[k] = !(height_stall && (&(v_reg | low_mask)));
        end
    end

    // valid bit entering each stage
    assign v_in = {v_reg[NUM_STAGES-2:0], column_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    assign column_stall = !en[0];
    assign height_valid = v_reg[S_OUT];

    // stage 0: offset sample point
    logic signed [AX_W-1:0] ax_reg;
    logic signed [AX_W-1:0] az_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ax_reg <= $signed({{2{column_x[COORD_W-1]}}, column_x, {FRAC_BITS{1'b0}}})
                      + $signed({2'b00, offx_reg});
            az_reg <= $signed({{2{column_z[COORD_W-1]}}, column_z, {FRAC_BITS{1'b0}}})
                      + $signed({2'b00, offz_reg});
        end
    end

    // stage 1: base frequency scale, only the cell and fraction bits are kept
    logic signed [AX_W+12:0] prx;
    logic signed [AX_W+12:0] prz;
    logic [POS_W-1:0]        nx_reg;
    logic [POS_W-1:0]        nz_reg;

    assign prx = ax_reg * $signed(13'(K_FREQ));
    assign prz = az_reg * $signed(13'(K_FREQ));

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            nx_reg <= prx[FRAC_BITS +: POS_W];
            nz_reg <= prz[FRAC_BITS +: POS_W];
        end
    end

    // octave lanes at doubling frequency
    logic signed [G_W-1:0] n_oct [OCTAVES];

    for (genvar o = 0; o < OCTAVES; o++)
    begin : g_oct
        fnth_octave u_octave (
            .clk   (clk),
            .en    (en[OCT0 +: OCT_STAGES]),
            .px    (nx_reg << o),
            .py    (offy_reg),
            .pz    (nz_reg << o),
            .noise (n_oct[o])
        );
    end

    // weighted octave sum, amplitude halves per octave
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;

    always_comb
    begin
        sum_next = '0;
        for (int o = 0; o < OCTAVES; o++)
        begin
            sum_next = sum_next + SUM_W'(n_oct[o] >>> o);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    // normalize: reciprocal product of the magnitude
    logic [SUM_W-1:0]   mag;
    logic [NN_W-1:0]    nn;
    logic [NN_W-1:0]    nn_reg;
    logic [NN_W+31:0]   rec_reg;
    logic               neg_rec_reg;

    assign mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign nn  = NN_W'(mag) << (OCTAVES - 1);

    always_ff @(posedge clk)
    begin
        if (en[S_REC])
        begin
            rec_reg     <= (NN_W+32)'(nn) * (NN_W+32)'(RECIP);
            nn_reg      <= nn;
            neg_rec_reg <= sum_reg[SUM_W-1];
        end
    end

    // normalize: quotient estimate is low by at most one
    logic [NN_W-1:0] q_est;
    logic [NN_W-1:0] rem;
    logic [NN_W-1:0] q_reg;
    logic            neg_q_reg;

    assign q_est = rec_reg[31 +: NN_W];
    assign rem   = nn_reg - NN_W'(q_est * NN_W'(DIV));

    always_ff @(posedge clk)
    begin
        if (en[S_Q])
        begin
            q_reg     <= (rem >= NN_W'(DIV)) ? q_est + NN_W'(1) : q_est;
            neg_q_reg <= neg_rec_reg;
        end
    end

    // map [-1,1] onto 0..MAX_HEIGHT with saturation
    logic signed [NN_W:0]     qs;
    logic signed [V_W-1:0]    vh;
    logic signed [V_W-1:0]    hsh;
    logic [HEIGHT_W-1:0]      height_next;
    logic [HEIGHT_W-1:0]      height_reg;

    assign qs  = neg_q_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign vh  = (V_W'(qs) + V_W'(ONE)) * V_W'(MAX_HEIGHT);
    assign hsh = vh >>> (FRAC_BITS + 1);

    always_comb
    begin
        if (vh < 0)
        begin
            height_next = '0;
        end
        else if (hsh > V_W'(MAX_HEIGHT))
        begin
            height_next = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            height_next = HEIGHT_W'(hsh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            height_reg <= height_next;
        end
    end

    assign height = height_reg;

endmodule

[src/fnth_checker.sv]
// fnth_checker: port level assertions for the terrain height generator
// depends on fnth_pkg; bound to fractal_noise_terrain_height at the end of this file
module fnth_checker #(
    parameter int MAX_HEIGHT = fnth_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fnth_pkg::ADDR_W-1:0]          paddr,
    input  logic [fnth_pkg::DATA_W-1:0]          pwdata,
    input  logic [fnth_pkg::DATA_W-1:0]          prdata,
    input  logic                                 column_stall,
    input  logic                                 height_valid,
    input  logic                                 height_stall,
    input  logic [fnth_pkg::HEIGHT_W-1:0]        height
);
    import fnth_pkg::*;

    // back pressure on the column side only comes from the height side
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        column_stall |-> height_stall)
        else $error("column stalled while height side is free");

    // a delivered height never exceeds a configured maximum of 127 or less
    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        height_valid |-> ((MAX_HEIGHT > 127) || (height <= HEIGHT_W'(MAX_HEIGHT))))
        else $error("height above maximum");

    // a stalled height transaction holds
    a_height_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (height_valid && height_stall) |=> (height_valid && $stable(height)))
        else $error("stalled height transaction changed");

    // seed read back after a write
    a_seed_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_SEED))
        |=> ((paddr[2] != REG_SEED) || (prdata == DATA_W'($past(pwdata[SEED_W-1:0])))))
        else $error("seed read back mismatch");

endmodule

bind fractal_noise_terrain_height fnth_checker #(
    .MAX_HEIGHT (MAX_HEIGHT)
) u_fnth_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .column_stall (column_stall),
    .height_valid (height_valid),
    .height_stall (height_stall),
    .height       (height)
);

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for the fractal noise terrain height generator
// depends on fnth_pkg and fractal_noise_terrain_height; holds its own fixed point height model
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fnth_pkg::*;

    localparam int LATENCY   = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int NUM_RAND  = 400;
    localparam logic [ADDR_W-1:0] ADDR_SEED = {ADDR_W{1'b0}};
    localparam logic [ADDR_W-1:0] ADDR_SPARE = 3'd4;

    // height predictor: fixed point terrain height for one column
    class height_board;
        logic [15:0] seed_q;
        logic [HEIGHT_W-1:0] pending[$];
        int errors;

        function new();
            seed_q = '0;
            errors = 0;
        endfunction

        function longint fmul(longint a, longint b);
            return (a * b) >>> FRAC_BITS;
        endfunction

        function longint fade_of(longint t);
            longint a;
            longint b;
            longint t3;
            a = 6 * t - 15 * longint'(ONE);
            b = fmul(t, a) + 10 * longint'(ONE);
            t3 = fmul(fmul(t, t), t);
            return fmul(t3, b);
        endfunction

        function longint grad_of(int hv, longint x, longint y, longint z);
            longint u;
            longint v;
            int h;
            h = hv & 15;
            u = (h < 8) ? x : y;
            v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
            return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
        endfunction

        function longint mix(longint f, longint a, longint b);
            return a + fmul(f, b - a);
        endfunction

        function int pm(int i);
            return int'(PERM_ROM[i & 255]);
        endfunction

        function longint gradient_noise(longint px, longint py, longint pz);
            int cx;
            int cy;
            int cz;
            longint x;
            longint y;
            longint z;
            longint fu;
            longint fv;
            longint fw;
            longint x1;
            longint y1;
            longint z1;
            int a;
            int b;
            int aa;
            int ab;
            int ba;
            int bb;
            longint l1;
            longint l2;
            longint l3;
            longint l4;
            cx = int'((px >>> FRAC_BITS) & 255);
            cy = int'((py >>> FRAC_BITS) & 255);
            cz = int'((pz >>> FRAC_BITS) & 255);
            x = px & (ONE - 1);
            y = py & (ONE - 1);
            z = pz & (ONE - 1);
            fu = fade_of(x);
            fv = fade_of(y);
            fw = fade_of(z);
            x1 = x - ONE;
            y1 = y - ONE;
            z1 = z - ONE;
            a = pm(cx) + cy;
            b = pm(cx + 1) + cy;
            aa = pm(a) + cz;
            ab = pm(a + 1) + cz;
            ba = pm(b) + cz;
            bb = pm(b + 1) + cz;
            l1 = mix(fu, grad_of(pm(aa), x, y, z), grad_of(pm(ba), x1, y, z));
            l2 = mix(fu, grad_of(pm(ab), x, y1, z), grad_of(pm(bb), x1, y1, z));
            l3 = mix(fu, grad_of(pm(aa + 1), x, y, z1), grad_of(pm(ba + 1), x1, y, z1));
            l4 = mix(fu, grad_of(pm(ab + 1), x, y1, z1), grad_of(pm(bb + 1), x1, y1, z1));
            return mix(fw, mix(fv, l1, l2), mix(fv, l3, l4));
        endfunction

        // note an accepted column and queue its expected height
        function void note_column(logic signed [15:0] cxi, logic signed [15:0] czi);
            longint s;
            longint ox;
            longint oy;
            longint oz;
            longint nx;
            longint nz;
            longint sum;
            longint total;
            longint norm;
            longint h;
            s = longint'(seed_q);
            ox = s * K_OFF_X;
            oz = s * K_OFF_Z;
            oy = s * K_OFF_Y;
            nx = fmul(longint'(cxi) * ONE + ox, K_FREQ);
            nz = fmul(longint'(czi) * ONE + oz, K_FREQ);
            sum = 0;
            total = 0;
            for (int o = 0; o < OCTAVES_DEF; o++)
            begin
                sum += gradient_noise(nx <<< o, oy, nz <<< o) >>> o;
                total += longint'(ONE) >> o;
            end
            norm = (sum * ONE) / total;
            h = ((norm + ONE) * MAX_HEIGHT_DEF) >>> (FRAC_BITS + 1);
            if (h < 0)
                h = 0;
            if (h > MAX_HEIGHT_DEF)
                h = MAX_HEIGHT_DEF;
            pending.push_back(h[HEIGHT_W-1:0]);
        endfunction

        // compare one delivered height with the oldest expectation
        function void check_height(logic [HEIGHT_W-1:0] got);
            logic [HEIGHT_W-1:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected height, expected none, actual %0d", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: height mismatch, expected %0d, actual %0d",
                         $realtime, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic column_valid;
    logic column_stall;
    logic signed [COORD_W-1:0] column_x;
    logic signed [COORD_W-1:0] column_z;
    logic height_valid;
    logic height_stall;
    logic [HEIGHT_W-1:0] height;

    height_board board;
    int idle_pct;
    int wdog;
    bit timed_out;

    fractal_noise_terrain_height u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .column_valid(column_valid), .column_stall(column_stall),
        .column_x(column_x), .column_z(column_z),
        .height_valid(height_valid), .height_stall(height_stall), .height(height)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // sink side: random stall and result check
    initial
    begin
        height_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && height_valid && !height_stall)
                board.check_height(height);
            height_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // watchdog on cycles with no transaction
    initial
    begin
        wdog = 0;
        timed_out = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((column_valid && !column_stall) || (height_valid && !height_stall)
                || board.pending.size() == 0)
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_MAX)
            begin
                $display("fractal_noise_terrain_height regression: fail");
                $finish;
            end
        end
    end

    // apb register write, setup then access
    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SEED)
            board.seed_q = data[15:0];
    endtask

    // send one column transaction, with a random gap first
    task automatic send_column(logic signed [15:0] x, logic signed [15:0] z);
        while ($urandom_range(99) < idle_pct)
        begin
            column_valid <= 1'b0;
            @(posedge clk);
        end
        column_valid <= 1'b1;
        column_x <= x;
        column_z <= z;
        do
            @(posedge clk);
        while (column_stall);
        board.note_column(x, z);
    endtask

    task automatic drain();
        column_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_columns(int n);
        logic [15:0] x;
        logic [15:0] z;
        for (int i = 0; i < n; i++)
        begin
            x = $urandom;
            z = $urandom;
            // mostly near the origin, where neighboring columns share cells
            if ($urandom_range(3) != 0)
            begin
                x = $signed(x[9:0]);
                z = $signed(z[9:0]);
            end
            send_column(x, z);
        end
    endtask

    initial
    begin
        logic [15:0] seeds[4];
        board = new();
        idle_pct = 37;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        column_valid = 1'b0;
        column_x = '0;
        column_z = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed columns at the default seed: coordinate extremes, small values and alternating bit patterns
        send_column(16'sh0000, 16'sh0000);
        send_column(16'sh7fff, 16'sh7fff);
        send_column(16'sh8000, 16'sh8000);
        send_column(16'sh7fff, 16'sh8000);
        send_column(16'sh8000, 16'sh7fff);
        send_column(-16'sd1, -16'sd1);
        send_column(16'sd1, 16'sd20);
        send_column(16'sh5555, 16'shaaaa);
        send_column(16'shaaaa, 16'sh5555);
        drain();

        // unknown register address must not move the seed
        apb_write(ADDR_SPARE, 32'h0000_1234);
        send_column(16'sd100, -16'sd100);
        drain();

        // extreme seeds, with bits above the register width set
        apb_write(ADDR_SEED, 32'hffff_ffff);
        send_column(16'sh0000, 16'sh0000);
        send_column(16'sh7fff, 16'sh8000);
        send_column(16'sd37, -16'sd911);
        drain();
        apb_write(ADDR_SEED, 32'h0001_0000);
        send_column(16'sd5, 16'sd5);
        drain();

        // random phases across several seeds; first phase has no idling
        seeds[0] = 16'h0000;
        seeds[1] = $urandom;
        seeds[2] = 16'hffff;
        seeds[3] = $urandom;
        for (int ph = 0; ph < 4; ph++)
        begin
            apb_write(ADDR_SEED, {16'h0, seeds[ph]});
            idle_pct = (ph == 0) ? 0 : 37;
            random_columns(NUM_RAND / 4);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("fractal_noise_terrain_height regression: pass");
        else
            $display("fractal_noise_terrain_height regression: fail");
        $finish;
    end

endmodule
